@@ design/bsp_pkg.sv @@
// Shared types and constants for the billboard sprite projector.
package bsp_pkg;

  localparam int SPRITES       = 4;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int SLOT_W        = (SPRITES > 1) ? $clog2(SPRITES) : 1;
  localparam int QDEPTH        = 2;

  localparam logic [1:0] OP_DEPTH  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_RENDER = 2'd2;

  localparam logic [0:0] REG_DIST_LIMIT   = 1'b0;
  localparam logic [0:0] REG_HEIGHT_RATIO = 1'b1;

  localparam logic [15:0] DIST_LIMIT_RST   = 16'd80;
  localparam logic [7:0]  HEIGHT_RATIO_RST = 8'd192;

  // render command handed from front to back
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
  } render_cmd_t;

  typedef struct packed {
    logic [7:0]  glyph;
    logic [5:0]  row_start;
    logic [5:0]  row_end;
    logic [5:0]  col_start;
    logic [5:0]  col_end;
    logic [63:0] column_mask;
    logic        last;
  } result_t;

endpackage

@@ design/bsp_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned 48 / 48.
module bsp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [47:0] den,
  output logic        done,
  output logic [47:0] quo
);
  logic [47:0] rem;
  logic [47:0] q;
  logic [47:0] d;
  logic [5:0]  cnt;
  logic        busy;
  logic [48:0] trial;

  assign trial = {1'b0, rem[46:0], q[47]} - {1'b0, d};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        q    <= num;
        d    <= den;
        cnt  <= 6'd0;
      end else if (busy) begin
        if (!trial[48]) begin
          rem <= trial[47:0];
          q   <= {q[46:0], 1'b1};
        end else begin
          rem <= {rem[46:0], q[47]};
          q   <= {q[46:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ design/bsp_front.sv @@
// Front end: decodes items, keeps the depth and sprite stores, queues renders.
module bsp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            opcode,
  input  logic [5:0]            slot,
  input  logic [15:0]           depth,
  input  logic signed [15:0]    sprite_x,
  input  logic signed [15:0]    sprite_y,
  input  logic [7:0]            glyph,
  input  bsp_pkg::render_cmd_t  cmd_in,
  output logic                  q_valid,
  output bsp_pkg::render_cmd_t  q_cmd,
  input  logic                  q_pop,
  input  logic                  back_busy,
  input  logic [5:0]            rd_col,
  output logic [15:0]           rd_depth,
  output logic [15:0]           spr_x [bsp_pkg::SPRITES],
  output logic [15:0]           spr_y [bsp_pkg::SPRITES],
  output logic [7:0]            spr_g [bsp_pkg::SPRITES],
  output logic [bsp_pkg::SPRITES-1:0] spr_v
);
  import bsp_pkg::*;

  logic [15:0]  depth_mem [64];
  render_cmd_t  fifo [QDEPTH];
  logic         wp, rp;
  logic [1:0]   count;
  logic         accept, push;

  // stores change only while no render is queued or running
  assign in_stall = (count == 2'(QDEPTH)) ||
                    ((opcode != OP_RENDER) && (q_valid || back_busy));
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (opcode == OP_RENDER);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = fifo[rp];

  always_ff @(posedge clk) begin
    if (accept && opcode == OP_DEPTH) depth_mem[slot] <= depth;
    rd_depth <= depth_mem[rd_col];
    if (push) fifo[wp] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
      spr_v <= '0;
      for (int i = 0; i < SPRITES; i++) begin
        spr_x[i] <= '0;
        spr_y[i] <= '0;
        spr_g[i] <= '0;
      end
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, q_pop};
      if (accept && opcode == OP_LOAD && {26'd0, slot} < SPRITES) begin
        spr_x[slot[SLOT_W-1:0]] <= sprite_x;
        spr_y[slot[SLOT_W-1:0]] <= sprite_y;
        spr_g[slot[SLOT_W-1:0]] <= glyph;
        spr_v[slot[SLOT_W-1:0]] <= 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'(QDEPTH))
    else $error("render queue overflow");
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty render queue");
  assert property (@(posedge clk) disable iff (rst)
      (back_busy && accept) |-> (opcode == OP_RENDER))
    else $error("store written during render");
endmodule

@@ design/bsp_back.sv @@
// Back end: sorts sprites, projects them through a shared divider, emits results.
module bsp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  bsp_pkg::render_cmd_t  q_cmd,
  output logic                  q_pop,
  output logic                  busy,
  output logic [5:0]            rd_col,
  input  logic [15:0]           rd_depth,
  input  logic [15:0]           spr_x [bsp_pkg::SPRITES],
  input  logic [15:0]           spr_y [bsp_pkg::SPRITES],
  input  logic [7:0]            spr_g [bsp_pkg::SPRITES],
  input  logic [bsp_pkg::SPRITES-1:0] spr_v,
  input  logic [15:0]           distance_limit,
  input  logic [7:0]            height_ratio,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bsp_pkg::result_t      res
);
  import bsp_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0,  S_DET  = 5'd1,  S_PICK = 5'd2,
                         S_EXY  = 5'd3,  S_MUL1 = 5'd4,  S_MUL2 = 5'd5,
                         S_DQ   = 5'd6,  S_DQW  = 5'd7,  S_SX   = 5'd8,
                         S_SXW  = 5'd9,  S_WL   = 5'd10, S_WLW  = 5'd11,
                         S_GEO  = 5'd12, S_SPAN = 5'd13, S_MSK  = 5'd14,
                         S_MSKW = 5'd15, S_PUSH = 5'd16, S_EMIT = 5'd17,
                         S_DIST = 5'd18;

  logic [4:0] state;
  render_cmd_t cmd;
  logic signed [32:0] det;
  logic signed [16:0] ex, ey;
  logic signed [33:0] m_a, m_b;
  logic signed [35:0] nx, ny;
  logic signed [47:0] dq;
  logic signed [47:0] sx;
  logic [47:0]        wall;
  logic [SPRITES-1:0] done_m;
  logic [SLOT_W-1:0]  cur, best;
  logic [SLOT_W:0]    scan;
  logic [35:0]        best_d, cur_d;
  logic               have;
  logic [7:0]         g;
  logic [5:0]         rs, re, cs, ce, col;
  logic [63:0]        mask;
  result_t            buf_r [4];
  logic [2:0]         cnt;
  logic [1:0]         wr, rdp;
  logic [2:0]         left;
  logic               div_start, div_done, neg;
  logic [47:0]        div_num, div_den, div_q;

  bsp_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  // squared distance of the scanned slot
  logic signed [16:0] sex, sey;
  assign sex   = 17'(signed'(spr_x[scan[SLOT_W-1:0]])) - 17'(cmd.pos_x);
  assign sey   = 17'(signed'(spr_y[scan[SLOT_W-1:0]])) - 17'(cmd.pos_y);

  logic [35:0]        scan_d;
  logic signed [35:0] ny_w;
  logic signed [47:0] sxn_w, quo_s, sx_sat;
  assign scan_d = 36'(sex * sex) + 36'(sey * sey);
  assign ny_w   = 36'(m_a) - 36'(m_b);
  // screen x numerator, sign of ny folded in so the divisor is |ny|
  assign sxn_w  = ny[35] ? -(48'(SCREEN_WIDTH / 2) * (48'(ny) + 48'(nx)))
                         : 48'(SCREEN_WIDTH / 2) * (48'(ny) + 48'(nx));
  assign quo_s  = neg ? -$signed(div_q) : $signed(div_q);
  assign sx_sat = (quo_s > 48'sd32767) ? 48'sd32767 :
                  (quo_s < -48'sd32767) ? -48'sd32767 : quo_s;

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign busy      = (state != S_IDLE);
  assign rd_col    = col;
  assign out_valid = (state == S_EMIT);
  assign res       = buf_r[rdp];

  logic signed [47:0] h, fl, t;
  logic signed [47:0] rs_w, re_w, cs_w, ce_w;
  always_comb begin
    h    = 48'(($signed({1'b0, wall}) * $signed({1'b0, height_ratio})) >>> 8);
    fl   = 48'(SCREEN_HEIGHT / 2) + 48'(wall >> 1);
    re_w = (fl >= SCREEN_HEIGHT) ? 48'(SCREEN_HEIGHT - 1) : fl;
    t    = fl - h;
    rs_w = (t < 0) ? 48'sd0 : t;
    cs_w = sx - (h >>> 1);
    if (cs_w < 0) cs_w = 48'sd0;
    ce_w = sx + (h >>> 1);
    if (ce_w >= SCREEN_WIDTH) ce_w = 48'(SCREEN_WIDTH - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      wr    <= '0;
      rdp   <= '0;
      left  <= '0;
      div_start <= 1'b0;
    end else begin
      div_start <= (state == S_DQ) ||
                   (state == S_DQW && div_done && !neg && div_q != '0) ||
                   (state == S_SXW && div_done);
      unique case (state)
        S_IDLE: if (q_valid) begin
          cmd <= q_cmd;
          state <= S_DET;
        end
        S_DET: begin
          m_a <= 34'(cmd.plane_x * cmd.dir_y);
          m_b <= 34'(cmd.dir_x * cmd.plane_y);
          done_m <= ~spr_v;
          cnt <= '0;
          wr <= '0;
          state <= S_DIST;
        end
        S_DIST: begin
          det <= 33'(m_a - m_b);
          scan <= '0;
          have <= 1'b0;
          state <= S_PICK;
        end
        // select farthest remaining; ties go to the lower slot
        S_PICK: begin
          if (scan == (SLOT_W+1)'(SPRITES)) begin
            if (!have) begin
              left <= cnt;
              rdp <= wr - 2'(cnt);
              state <= (cnt == 3'd0) ? S_IDLE : S_EMIT;
            end else begin
              done_m[best] <= 1'b1;
              cur <= best;
              cur_d <= best_d;
              state <= S_EXY;
            end
          end else begin
            if (!done_m[scan[SLOT_W-1:0]]) begin
              if (!have || scan_d > best_d) begin
                best <= scan[SLOT_W-1:0];
                best_d <= scan_d;
                have <= 1'b1;
              end
            end
            scan <= scan + 1'b1;
          end
        end
        S_EXY: begin
          ex <= 17'(signed'(spr_x[cur])) - 17'(cmd.pos_x);
          ey <= 17'(signed'(spr_y[cur])) - 17'(cmd.pos_y);
          g  <= spr_g[cur];
          scan <= '0;
          have <= 1'b0;
          if (cur_d > {4'd0, distance_limit, 16'd0} || det == 0) state <= S_PICK;
          else state <= S_MUL1;
        end
        S_MUL1: begin
          m_a <= 34'(cmd.dir_y * ex);
          m_b <= 34'(cmd.dir_x * ey);
          state <= S_MUL2;
        end
        S_MUL2: begin
          nx  <= 36'(m_a) - 36'(m_b);
          m_a <= 34'(cmd.plane_x * ey);
          m_b <= 34'(cmd.plane_y * ex);
          state <= S_DQ;
        end
        S_DQ: begin
          ny <= ny_w;
          neg <= ny_w[35] ^ det[32];
          div_num <= 48'(ny_w[35] ? -ny_w : ny_w) << 14;
          div_den <= 48'(det[32] ? -det : det);
          state <= S_DQW;
        end
        S_DQW: if (div_done) begin
          dq <= quo_s;
          if (neg || div_q == '0) begin
            state <= S_PICK;
          end else begin
            neg <= sxn_w[47];
            div_num <= sxn_w[47] ? -sxn_w : sxn_w;
            div_den <= 48'(ny[35] ? -ny : ny);
            state <= S_SXW;
          end
        end
        S_SXW: if (div_done) begin
          sx <= sx_sat;
          div_num <= 48'(SCREEN_HEIGHT * 256);
          div_den <= dq;
          state <= S_WLW;
        end
        S_WLW: if (div_done) begin
          wall <= div_q;
          state <= S_GEO;
        end
        S_GEO: begin
          if (rs_w >= re_w) begin rs <= '0; re <= '0; end
          else begin rs <= rs_w[5:0]; re <= re_w[5:0]; end
          mask <= '0;
          if (cs_w >= ce_w) begin
            cs <= '0; ce <= '0;
            state <= S_PUSH;
          end else begin
            cs <= cs_w[5:0]; ce <= ce_w[5:0];
            col <= cs_w[5:0];
            state <= S_MSK;
          end
        end
        // depth store read-data is registered, so each column waits in S_MSK before S_MSKW compares it
        S_MSK: state <= S_MSKW;
        S_MSKW: begin
          if (dq < $signed({32'd0, rd_depth})) mask[col] <= 1'b1;
          if (col + 6'd1 == ce) state <= S_PUSH;
          else begin
            col <= col + 6'd1;
            state <= S_MSK;
          end
        end
        S_PUSH: begin
          buf_r[wr] <= '{glyph: g, row_start: rs, row_end: re, col_start: cs,
                         col_end: ce, column_mask: mask, last: 1'b0};
          wr <= wr + 2'd1;
          if (cnt != 3'd4) cnt <= cnt + 3'd1;
          state <= S_PICK;
        end
        S_EMIT: if (!out_stall) begin
          rdp <= rdp + 2'd1;
          left <= left - 3'd1;
          if (left == 3'd1) state <= S_IDLE;
        end
        S_SX, S_WL, S_SPAN: state <= S_PICK;
        default: state <= S_IDLE;
      endcase
      if (state == S_EMIT && !out_stall && left == 3'd1) buf_r[rdp].last <= 1'b0;
      if (state == S_PICK && scan == (SLOT_W+1)'(SPRITES) && !have && cnt != 3'd0)
        buf_r[wr - 2'd1].last <= 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("result count overflow");
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst) q_pop |=> busy)
    else $error("render not started");
endmodule

@@ design/billboard_sprite_projector.sv @@
// Top level of the billboard sprite projector: config registers, front and back.
// Depth writes and sprite loads are accepted only while no render is queued or running.
// A render sorts by repeated scans of the slots, one scan per valid sprite plus one,
// after set-up in S_DET and S_DIST. Each sprite drawn then uses three divisions on the
// shared bit-serial divider, and one depth store read per column of its span.
// A sprite beyond the limit is dropped before any division, one behind the camera after
// the first division. Up to four results then leave one per unstalled cycle.
module billboard_sprite_projector (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [5:0]         slot,
  input  logic [15:0]        depth,
  input  logic signed [15:0] sprite_x,
  input  logic signed [15:0] sprite_y,
  input  logic [7:0]         glyph,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] plane_x,
  input  logic signed [15:0] plane_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_glyph,
  output logic [5:0]         row_start,
  output logic [5:0]         row_end,
  output logic [5:0]         col_start,
  output logic [5:0]         col_end,
  output logic [63:0]        column_mask,
  output logic               last
);
  import bsp_pkg::*;

  logic [15:0] distance_limit;
  logic [7:0]  height_ratio;
  render_cmd_t cmd_in, q_cmd;
  logic        q_valid, q_pop, back_busy;
  logic [5:0]  rd_col;
  logic [15:0] rd_depth;
  logic [15:0] spr_x [SPRITES];
  logic [15:0] spr_y [SPRITES];
  logic [7:0]  spr_g [SPRITES];
  logic [SPRITES-1:0] spr_v;
  result_t     res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_limit <= DIST_LIMIT_RST;
      height_ratio   <= HEIGHT_RATIO_RST;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      if (paddr[2] == REG_DIST_LIMIT) distance_limit <= pwdata[15:0];
      else height_ratio <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == 3'd0) prdata = {16'd0, distance_limit};
    else if (paddr == 3'd4) prdata = {24'd0, height_ratio};
  end

  assign cmd_in = '{pos_x: pos_x, pos_y: pos_y, dir_x: dir_x, dir_y: dir_y,
                    plane_x: plane_x, plane_y: plane_y};

  bsp_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .slot(slot), .depth(depth), .sprite_x(sprite_x),
    .sprite_y(sprite_y), .glyph(glyph), .cmd_in(cmd_in), .q_valid(q_valid),
    .q_cmd(q_cmd), .q_pop(q_pop), .back_busy(back_busy), .rd_col(rd_col),
    .rd_depth(rd_depth), .spr_x(spr_x), .spr_y(spr_y), .spr_g(spr_g),
    .spr_v(spr_v)
  );

  bsp_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .busy(back_busy), .rd_col(rd_col), .rd_depth(rd_depth), .spr_x(spr_x),
    .spr_y(spr_y), .spr_g(spr_g), .spr_v(spr_v),
    .distance_limit(distance_limit), .height_ratio(height_ratio),
    .out_valid(out_valid), .out_stall(out_stall), .res(res)
  );

  assign out_glyph   = res.glyph;
  assign row_start   = res.row_start;
  assign row_end     = res.row_end;
  assign col_start   = res.col_start;
  assign col_end     = res.col_end;
  assign column_mask = res.column_mask;
  assign last        = res.last;
endmodule
